// ===== design/csf_pkg.sv =====
package csf_pkg;

  // sizing of the block
  localparam int unsigned PATTERN_MAX = 63;
  localparam int unsigned MAX_MATCHES = 256;
  localparam int unsigned MAX_STRINGS = 65536;

  localparam int unsigned LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned IDX_W  = $clog2(MAX_STRINGS + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_MATCHES + 1);

  // fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SIDX_W  = 16;
  localparam int unsigned MNUM_W  = 8;
  localparam int unsigned OUT_W   = SIDX_W + MNUM_W;

  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  typedef enum logic [1:0] {
    CMD_NEW    = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_BYTE   = 2'd2,
    CMD_EMPTY  = 2'd3
  } cmd_e;

  // one classified word as it waits between front and back
  typedef struct packed {
    cmd_e              cmd;
    logic [CHAR_W-1:0] ch;    // already case folded
    logic              last;  // only set for a closing string byte
  } item_t;

  // head of the queue as the back end sees it
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= UPPER_FIRST && c <= UPPER_LAST) r = c + CASE_OFFSET;
    return r;
  endfunction

endpackage

// ===== design/csf_front.sv =====
module csf_front (
  input  logic [1:0]                s_tuser_i,
  input  logic [csf_pkg::CHAR_W-1:0] s_tdata_i,
  input  logic                      s_tlast_i,
  output csf_pkg::item_t            item_o
);
  import csf_pkg::*;

  cmd_e cmd;

  always_comb begin
    cmd = cmd_e'(s_tuser_i);
    item_o.cmd  = cmd;
    item_o.ch   = fold_byte(s_tdata_i);
    // the last flag only means something on a string byte
    item_o.last = (cmd == CMD_BYTE) && s_tlast_i;
  end

endmodule

// ===== design/csf_queue.sv =====
module csf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  csf_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output csf_pkg::head_t head_o
);
  import csf_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o      = (cnt_q != 2'd2);
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

// ===== design/csf_back.sv =====
module csf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  csf_pkg::head_t            head_i,
  output logic                      pop_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [csf_pkg::OUT_W-1:0] m_tdata_o
);
  import csf_pkg::*;

  logic [CHAR_W-1:0]      pat_q [PATTERN_MAX];
  logic [LEN_W-1:0]       len_q, len_d;
  logic [PATTERN_MAX-1:0] vec_q, vec_d;
  logic                   found_q, found_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [SIDX_W-1:0]      out_idx_q;
  logic [MNUM_W-1:0]      out_num_q;

  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] vec_step;
  logic [PIDX_W-1:0]      tail_pos;
  logic                   byte_found;
  logic                   closing, close_match, emit;
  logic                   pat_we;
  item_t                  it;

  assign it    = head_i.item;
  assign pop_o = head_i.valid && (!out_valid_q || m_tready_i);

  // every pattern position compares against the byte in parallel
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq[i] = (pat_q[i] == it.ch) && (LEN_W'(i) < len_q);
    end
  end

  assign vec_step   = ((vec_q << 1) | PATTERN_MAX'(1)) & eq;
  assign tail_pos   = PIDX_W'(len_q - LEN_W'(1));
  assign byte_found = found_q || (len_q == '0) || vec_step[tail_pos];

  always_comb begin
    len_d       = len_q;
    vec_d       = vec_q;
    found_d     = found_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    closing     = 1'b0;
    close_match = 1'b0;
    pat_we      = 1'b0;
    emit        = 1'b0;
    if (pop_o) begin
      case (it.cmd)
        CMD_NEW: begin
          len_d   = '0;
          vec_d   = '0;
          found_d = 1'b0;
          idx_d   = '0;
          cnt_d   = '0;
        end
        CMD_APPEND: begin
          if (len_q < LEN_W'(PATTERN_MAX)) begin
            pat_we = 1'b1;
            len_d  = len_q + LEN_W'(1);
          end
        end
        CMD_BYTE: begin
          vec_d       = vec_step;
          found_d     = byte_found;
          closing     = it.last;
          close_match = byte_found;
        end
        CMD_EMPTY: begin
          closing     = 1'b1;
          close_match = (len_q == '0);
        end
        default: ;
      endcase
      if (closing) begin
        emit = close_match && (cnt_q < CNT_W'(MAX_MATCHES))
            && (idx_q < IDX_W'(MAX_STRINGS));
        if (emit) cnt_d = cnt_q + CNT_W'(1);
        if (idx_q < IDX_W'(MAX_STRINGS)) idx_d = idx_q + IDX_W'(1);
        vec_d   = '0;
        found_d = 1'b0;
      end
    end
    if (emit)            out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
    else                 out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      vec_q       <= '0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      vec_q       <= vec_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pattern bytes and result payload carry no reset
  always_ff @(posedge clk_i) begin
    if (pat_we) pat_q[len_q[PIDX_W-1:0]] <= it.ch;
    if (emit) begin
      out_idx_q <= SIDX_W'(idx_q);
      out_num_q <= MNUM_W'(cnt_q);
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_num_q, out_idx_q};

endmodule

// ===== design/caseless_substring_filter_unit.sv =====
// caseless substring filter
// input stream: one word per command. s_tuser_i carries the command (new search,
// append pattern byte, string byte, empty string), s_tdata_i the byte and
// s_tlast_i closes a string on a string byte. a word is taken when s_tvalid_i
// and s_tready_o are both high.
// output stream: one word for each closed string that contains the pattern,
// ignoring ascii letter case; m_tdata_o holds the string index since the last
// new search and the ordinal of the match. only the first 256 matches and the
// first 65536 strings are reported.
// throughput: one word per cycle while the result register is not stalled, set by
// the shift-and update that compares the byte against all pattern positions in parallel.
// output path: the closing word is written into the queue, then the back end takes
// it and sets the output register, which drives m_tvalid_o.
// reset: the pattern is empty and the string and match counters are zero.
// stall: while m_tready_i is low the result holds, the back end stops and the
// queue fills; s_tready_o drops once the queue holds two words.
module caseless_substring_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // char_in[7:0]
  input  logic [1:0]  s_tuser_i,   // command[1:0]
  input  logic        s_tlast_i,   // last_of_string
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o    // string_index[15:0], match_number[23:16]
);
  import csf_pkg::*;

  item_t front_item;
  head_t q_head;
  logic  q_ready;
  logic  q_pop;

  // front: decode the command and fold the byte
  csf_front u_front (
    .s_tuser_i (s_tuser_i),
    .s_tdata_i (s_tdata_i),
    .s_tlast_i (s_tlast_i),
    .item_o    (front_item)
  );

  // two-word queue decouples the input side from the result side
  csf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_tvalid_i),
    .item_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  assign s_tready_o = q_ready;

  // back: pattern store, shift-and vector, counters and result register
  csf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .pop_o      (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  // back end only pulls a word that is there
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head.valid)
    else $error("pop from empty queue");

  // a full queue must have a word to offer
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> q_head.valid)
    else $error("queue blocks input while empty");

  // a taken word is visible to the back end next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> q_head.valid)
    else $error("accepted word lost");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import csf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;  // cycles without any handshake
  localparam int unsigned HOLD_CYCLES = 60;    // long receiver hold-off
  localparam int unsigned RAND_WORDS  = 1100;

  typedef struct packed {
    logic [15:0] idx;
    logic [7:0]  num;
  } hit_t;

  // one line of the directed table; a fixed result is used where it is obvious
  typedef struct {
    cmd_e       cmd;
    logic [7:0] ch;
    logic       last;
    bit         fixed;
    bit         fixed_hit;
    hit_t       fixed_res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i;   // char_in[7:0]
  logic [1:0]  s_tuser_i;   // command[1:0]
  logic        s_tlast_i;   // last_of_string
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [23:0] m_tdata_o;   // string_index[15:0], match_number[23:16]

  caseless_substring_filter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  // predictor state
  logic [7:0]  pat_bytes [PATTERN_MAX];
  int          pat_len;
  logic [62:0] prefix_hits;
  bit          seen_pattern;
  int          str_index;
  int          hit_count;

  hit_t        hits_due [$];
  row_t        dir_rows [$];
  int          errors;
  int          results_seen;
  int          words_sent;
  int          quiet_cycles;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic void close_string(input bit matched, output bit hit, output hit_t res);
    hit = 1'b0;
    res = '0;
    if (matched && hit_count < MAX_MATCHES && str_index < MAX_STRINGS) begin
      hit = 1'b1;
      res.idx = str_index[15:0];
      res.num = hit_count[7:0];
      hit_count++;
    end
    if (str_index < MAX_STRINGS) str_index++;
    prefix_hits  = '0;
    seen_pattern = 1'b0;
  endfunction

  // shift-and filter, one input word
  function automatic void filter_step(input cmd_e cmd, input logic [7:0] ch, input logic last,
                                      output bit hit, output hit_t res);
    logic [62:0] eq;
    hit = 1'b0;
    res = '0;
    case (cmd)
      CMD_NEW: begin
        pat_len      = 0;
        prefix_hits  = '0;
        seen_pattern = 1'b0;
        str_index    = 0;
        hit_count    = 0;
      end
      CMD_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = ch;
          pat_len++;
        end
      end
      CMD_BYTE: begin
        eq = '0;
        for (int i = 0; i < pat_len; i++)
          if (to_lower(pat_bytes[i]) == to_lower(ch)) eq[i] = 1'b1;
        prefix_hits = ((prefix_hits << 1) | 63'd1) & eq;
        if (pat_len == 0 || prefix_hits[pat_len-1]) seen_pattern = 1'b1;
        if (last) close_string(seen_pattern, hit, res);
      end
      default: begin
        // an open string is dropped, the empty one matches only an empty pattern
        prefix_hits  = '0;
        seen_pattern = 1'b0;
        close_string(pat_len == 0, hit, res);
      end
    endcase
  endfunction

  // drive one word, wait for the handshake, then log what should come out
  task automatic send_row(input row_t r);
    int   gap;
    bit   hit;
    hit_t res;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid_i <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= r.cmd;
    s_tdata_i  <= r.ch;
    s_tlast_i  <= r.last;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    filter_step(r.cmd, r.ch, r.last, hit, res);
    if (r.fixed) begin
      hit = r.fixed_hit;
      res = r.fixed_res;
    end
    if (hit) hits_due.push_back(res);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic word(input cmd_e cmd, input logic [7:0] ch, input logic last);
    row_t r;
    r.cmd       = cmd;
    r.ch        = ch;
    r.last      = last;
    r.fixed     = 1'b0;
    r.fixed_hit = 1'b0;
    r.fixed_res = '0;
    send_row(r);
  endtask

  task automatic add_row(input cmd_e cmd, input logic [7:0] ch, input logic last,
                         input bit fixed, input bit fixed_hit,
                         input logic [15:0] idx, input logic [7:0] num);
    row_t r;
    r.cmd           = cmd;
    r.ch            = ch;
    r.last          = last;
    r.fixed         = fixed;
    r.fixed_hit     = fixed_hit;
    r.fixed_res.idx = idx;
    r.fixed_res.num = num;
    dir_rows.push_back(r);
  endtask

  // mostly a small alphabet so that patterns show up, plus case boundaries and noise
  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return flip_case(8'h61 + 8'($urandom_range(0, 2)));
    if (k < 9) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'h40;
      1: return 8'h5B;
      2: return 8'h60;
      default: return 8'h7B;
    endcase
  endfunction

  // new search, a pattern, then strings that often carry it in mixed case
  task automatic run_search();
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    logic [7:0] c;
    int         plen;
    int         nstr;
    int         slen;
    int         pos;
    bit         embed;
    word(CMD_NEW, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    plen = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 4);
    repeat (plen) begin
      c = pick_char();
      pat.push_back(c);
      word(CMD_APPEND, c, 1'($urandom_range(0, 1)));
    end
    nstr = $urandom_range(2, 8);
    repeat (nstr) begin
      if ($urandom_range(0, 9) == 0) begin
        word(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        embed = pat.size() > 0 && $urandom_range(0, 1);
        slen  = embed ? pat.size() + $urandom_range(0, 5) : $urandom_range(1, 10);
        txt.delete();
        repeat (slen) txt.push_back(pick_char());
        if (embed) begin
          pos = $urandom_range(0, slen - pat.size());
          foreach (pat[k]) txt[pos+k] = flip_case(pat[k]);
        end
        foreach (txt[k]) begin
          // now and then the pattern grows in the middle of a string
          if ($urandom_range(0, 29) == 0) word(CMD_APPEND, pick_char(), 1'($urandom_range(0, 1)));
          word(CMD_BYTE, txt[k], k == txt.size() - 1);
        end
      end
    end
  endtask

  // receiver: one long hold-off once results flow, then short random stalls
  initial begin
    int n;
    m_tready_i = 1'b1;
    wait (results_seen >= 3);
    @(negedge clk_i);
    m_tready_i <= 1'b0;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    m_tready_i <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready_i <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n) @(negedge clk_i);
      end
      m_tready_i <= 1'b1;
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      results_seen++;
      if (hits_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual idx %0d num %0d",
                 $time, m_tdata_o[15:0], m_tdata_o[23:16]);
      end else begin
        want = hits_due.pop_front();
        if (m_tdata_o[15:0] !== want.idx) begin
          errors++;
          $display("%0t: string_index expected %0d actual %0d", $time, want.idx, m_tdata_o[15:0]);
        end
        if (m_tdata_o[23:16] !== want.num) begin
          errors++;
          $display("%0t: match_number expected %0d actual %0d", $time, want.num,
                   m_tdata_o[23:16]);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    errors       = 0;
    results_seen = 0;
    words_sent   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    pat_len      = 0;
    prefix_hits  = '0;
    seen_pattern = 1'b0;
    str_index    = 0;
    hit_count    = 0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    s_tuser_i    = CMD_NEW;
    s_tlast_i    = 1'b0;
    rst_ni       = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty pattern after reset matches every string
    add_row(CMD_EMPTY,  8'hFF, 1'b1, 1, 1, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h78, 1'b1, 1, 1, 16'd1, 8'd1);
    add_row(CMD_NEW,    8'hFF, 1'b1, 1, 0, 16'd0, 8'd0);
    // pattern "Az", compared without case
    add_row(CMD_APPEND, 8'h41, 1'b1, 0, 0, 16'd0, 8'd0);
    add_row(CMD_APPEND, 8'h7A, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h61, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h5A, 1'b1, 1, 1, 16'd0, 8'd0);
    // empty string with a pattern loaded never matches
    add_row(CMD_EMPTY,  8'h00, 1'b0, 1, 0, 16'd0, 8'd0);
    // bytes next to the letter ranges stay as they are
    add_row(CMD_BYTE,   8'h40, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h7B, 1'b1, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h60, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h5B, 1'b1, 0, 0, 16'd0, 8'd0);
    // byte extremes, then the pattern grows mid-string to "Azc"
    add_row(CMD_BYTE,   8'h00, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'hFF, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h61, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_APPEND, 8'h63, 1'b1, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h7A, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h43, 1'b1, 0, 0, 16'd0, 8'd0);
    // an empty string drops the open one that was about to match
    add_row(CMD_BYTE,   8'h41, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h5A, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_EMPTY,  8'h63, 1'b1, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h63, 1'b1, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h61, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h7A, 1'b0, 0, 0, 16'd0, 8'd0);
    add_row(CMD_BYTE,   8'h63, 1'b1, 0, 0, 16'd0, 8'd0);
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // random: mostly well-formed searches, some loose words
    while (words_sent < dir_rows.size() + RAND_WORDS) begin
      idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 6) != 0) run_search();
      else repeat ($urandom_range(1, 6))
        word(cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end

    // no idling from here on
    idle_on = 1'b0;

    // full pattern: extra appends are dropped
    word(CMD_NEW, 8'h00, 1'b0);
    repeat (70) word(CMD_APPEND, flip_case(8'h61), 1'b0);
    repeat (62) word(CMD_BYTE, flip_case(8'h61), 1'b0);
    word(CMD_BYTE, 8'h41, 1'b1);
    repeat (61) word(CMD_BYTE, 8'h61, 1'b0);
    word(CMD_BYTE, 8'h61, 1'b1);

    // match limit: empty pattern, more empty strings than reportable matches
    word(CMD_NEW, 8'h00, 1'b0);
    repeat (MAX_MATCHES + 40)
      word(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    s_tvalid_i <= 1'b0;

    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
